/* design/rato_pkg.sv */
// Rotor angle tracking observer: shared types and constants.
// Command and status records between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps

package rato_pkg;

  localparam int DATA_W     = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [15:0] S16_MAX = 16'sh7fff;
  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;

  // gain boost divider: |speed| * mult dividend, 15-bit divisor
  localparam int DIVIDEND_W = 30;
  localparam int DIVISOR_W  = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP_GAIN      = 4'd0,
    CFG_KI_GAIN      = 4'd1,
    CFG_KD_GAIN_BASE = 4'd2,
    CFG_KP_SHIFT     = 4'd3,
    CFG_KI_SHIFT     = 4'd4,
    CFG_KD_SHIFT     = 4'd5,
    CFG_SPEED_MULT   = 4'd6,
    CFG_SPEED_DIV    = 4'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_TT,
    MUL_C3T2,
    MUL_PT2,
    MUL_TP,
    MUL_MAG,
    MUL_BG,
    MUL_KP,
    MUL_KI
  } mul_op_e;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_T2,
    WB_P1,
    WB_P2,
    WB_P3,
    WB_SIN,
    WB_MAG,
    WB_KD,
    WB_KP,
    WB_KI
  } wb_op_e;

  typedef struct packed {
    logic    load_in;
    logic    clr;
    logic    sine_idx;
    mul_op_e mul_op;
    wb_op_e  wb_op;
    logic    gain;
    logic    upd1;
    logic    upd2;
    logic    est1;
    logic    est2;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic kind_clear;
    logic div_done;
  } status_t;

endpackage

/* design/rato_if.sv */
// Rotor angle tracking observer: valid/ready channel interfaces.
// Input item, result item and configuration write channels.
// Depends on rato_pkg.
`timescale 1ns / 1ps

interface rato_in_if;
  import rato_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic signed [DATA_W-1:0] hall_angle;
  logic signed [DATA_W-1:0] hall_speed;
  logic signed [DATA_W-1:0] drive_torque;
  modport source (output valid, kind, hall_angle, hall_speed, drive_torque, input ready);
  modport sink   (input valid, kind, hall_angle, hall_speed, drive_torque, output ready);
endinterface

interface rato_out_if;
  import rato_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] est_angle;
  logic signed [DATA_W-1:0] est_speed;
  logic signed [DATA_W-1:0] est_torque;
  modport source (output valid, est_angle, est_speed, est_torque, input ready);
  modport sink   (input valid, est_angle, est_speed, est_torque, output ready);
endinterface

interface rato_cfg_if;
  import rato_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* design/rato_div.sv */
// Rotor angle tracking observer: restoring divider, one quotient bit per cycle.
// Used for the speed-dependent gain boost. Depends on rato_pkg.
`timescale 1ns / 1ps

module rato_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [rato_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  logic [rato_pkg::DIVISOR_W-1:0]    divisor_i,
  output logic [rato_pkg::DIVIDEND_W-1:0]   quot_o,
  output logic                              done_o
);
  import rato_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic [CNT_W-1:0]      count_q;
  logic                  busy_q, done_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q, div_q;
  logic [DIVISOR_W:0]    rem_sh, rem_sub;
  logic                  ge;

  assign rem_sh  = {rem_q, quo_q[DIVIDEND_W-1]};
  assign ge      = rem_sh >= {1'b0, div_q};
  assign rem_sub = rem_sh - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else if (start_i) begin
      count_q <= CNT_W'(DIVIDEND_W - 1);
      busy_q  <= 1'b1;
      done_q  <= 1'b0;
    end else if (busy_q) begin
      if (count_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
      rem_q <= ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule

/* design/rato_dp.sv */
// Rotor angle tracking observer: datapath.
// Config registers, accumulators, shared multiplier, sine polynomial, estimate
// conversion; instantiates rato_div. Depends on rato_pkg.
`timescale 1ns / 1ps

module rato_dp #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rato_pkg::cmd_t                      cmd_i,
  output rato_pkg::status_t                   status_o,
  input  logic                                kind_i,
  input  logic signed [rato_pkg::DATA_W-1:0]  hall_angle_i,
  input  logic signed [rato_pkg::DATA_W-1:0]  hall_speed_i,
  input  logic signed [rato_pkg::DATA_W-1:0]  drive_torque_i,
  input  logic                                cfg_we_i,
  input  logic [rato_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rato_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic signed [rato_pkg::DATA_W-1:0]  est_angle_o,
  output logic signed [rato_pkg::DATA_W-1:0]  est_speed_o,
  output logic signed [rato_pkg::DATA_W-1:0]  est_torque_o
);
  import rato_pkg::*;

  localparam int QW  = SINE_TABLE_BITS - 2;
  localparam int TSH = 17 - SINE_TABLE_BITS;

  localparam logic [15:0] SIN_C0 = 16'd51472;
  localparam logic [15:0] SIN_C1 = 16'd21167;
  localparam logic [15:0] SIN_C2 = 16'd2611;
  localparam logic [15:0] SIN_C3 = 16'd153;

  localparam logic signed [31:0] GAIN_LIM = 32'sd32767;
  localparam logic signed [34:0] SAT_HI   = 35'(S32_MAX);
  localparam logic signed [34:0] SAT_LO   = -SAT_HI;
  localparam logic [32:0]        SCALE    = 33'd32767;

  function automatic logic signed [31:0] sat_acc(input logic signed [34:0] v);
    if (v > SAT_HI) return S32_MAX;
    if (v < SAT_LO) return -S32_MAX;
    return v[31:0];
  endfunction

  // configuration
  logic signed [15:0]    kp_gain_q, ki_gain_q, kd_gain_base_q;
  logic [4:0]            kp_shift_q, ki_shift_q, kd_shift_q;
  logic [DIVISOR_W-1:0]  speed_mult_q, speed_div_q, div_eff;

  // observer state
  logic [31:0]        angle_acc_q, speed_acc_q, torque_acc_q;
  logic signed [15:0] angle_est_q, speed_est_q, torque_est_q;

  // item and working registers
  logic               kind_q;
  logic signed [15:0] hall_angle_q, hall_speed_q, drive_torque_q;
  logic [15:0]        t_q, t2_q, p_q;
  logic               sin_neg_q;
  logic signed [15:0] e_q, bg_q;
  logic signed [35:0] prod_q;
  logic signed [31:0] term_a_q, term_s_q, term_t_q;
  logic signed [34:0] tmp_s_q;
  logic [31:0]        x_q  [3];
  logic [16:0]        q0_q [3];
  logic               neg_q[3];
  logic signed [15:0] out_angle_q, out_speed_q, out_torque_q;

  // sine argument
  logic [15:0]                diff;
  logic [SINE_TABLE_BITS-1:0] idx;
  logic [QW-1:0]              q_lo;
  logic [QW:0]                q_ref;
  logic [15:0]                t_d;

  assign diff  = hall_angle_q - angle_est_q;
  assign idx   = diff[15 -: SINE_TABLE_BITS];
  assign q_lo  = idx[QW-1:0];
  assign q_ref = idx[QW] ? ({1'b1, {QW{1'b0}}} - {1'b0, q_lo}) : {1'b0, q_lo};
  assign t_d   = {q_ref, {TSH{1'b0}}};

  // shared multiplier
  logic [15:0]        spd_mag;
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod_d;
  logic [15:0]        prod_hi, sin_mag;
  logic signed [15:0] e_d;

  assign spd_mag = speed_est_q[15] ? 16'(-speed_est_q) : 16'(speed_est_q);

  always_comb begin
    unique case (cmd_i.mul_op)
      MUL_TT:   begin mul_a = $signed({2'b00, t_q});  mul_b = $signed({2'b00, t_q});  end
      MUL_C3T2: begin mul_a = $signed({2'b00, SIN_C3}); mul_b = $signed({2'b00, t2_q}); end
      MUL_PT2:  begin mul_a = $signed({2'b00, p_q});  mul_b = $signed({2'b00, t2_q}); end
      MUL_TP:   begin mul_a = $signed({2'b00, t_q});  mul_b = $signed({2'b00, p_q});  end
      MUL_MAG:  begin
        mul_a = $signed({2'b00, spd_mag});
        mul_b = $signed({3'b000, speed_mult_q});
      end
      MUL_BG:   begin mul_a = 18'(bg_q);      mul_b = 18'(e_q); end
      MUL_KP:   begin mul_a = 18'(kp_gain_q); mul_b = 18'(e_q); end
      MUL_KI:   begin mul_a = 18'(ki_gain_q); mul_b = 18'(e_q); end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod_d  = mul_a * mul_b;
  assign prod_hi = prod_q[30:15];
  assign sin_mag = (prod_hi > 16'(S16_MAX)) ? 16'(S16_MAX) : prod_hi;
  assign e_d     = sin_neg_q ? -$signed(sin_mag) : $signed(sin_mag);

  // gain boost divider
  logic [DIVIDEND_W-1:0] div_quot;
  logic                  div_done;

  assign div_eff = (speed_div_q == '0) ? DIVISOR_W'(1) : speed_div_q;

  rato_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.wb_op == WB_MAG),
    .dividend_i (prod_q[DIVIDEND_W-1:0]),
    .divisor_i  (div_eff),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  logic signed [31:0] bg_sum;
  logic signed [15:0] bg_d;

  assign bg_sum = $signed({2'b00, div_quot}) + 32'(kd_gain_base_q);
  assign bg_d   = (bg_sum > GAIN_LIM) ? 16'(GAIN_LIM) :
                  (bg_sum < -GAIN_LIM) ? 16'(-GAIN_LIM) : bg_sum[15:0];

  // accumulator update
  logic signed [31:0] oa, os, ot, na, ns, nt;
  logic signed [34:0] dt35, tmp_s_d;
  logic signed [31:0] ha32, hs32;

  assign oa      = $signed(angle_acc_q);
  assign os      = $signed(speed_acc_q);
  assign ot      = $signed(torque_acc_q);
  assign dt35    = 35'(drive_torque_q);
  assign na      = oa + os + term_a_q;
  assign tmp_s_d = 35'(os) - 35'(ot) + ((dt35 <<< 15) - dt35);
  assign nt      = sat_acc(35'(ot) + 35'(term_t_q));
  assign ns      = sat_acc(tmp_s_q + 35'(term_s_q));
  assign ha32    = 32'(hall_angle_q);
  assign hs32    = 32'(hall_speed_q);

  // accumulator over 32767, toward zero: estimate then one correction
  logic [31:0] acc_v [3];
  logic [31:0] x_d   [3];
  logic [32:0] sum_d [3];
  logic [32:0] rem_d [3];
  logic [16:0] q_d   [3];
  logic [15:0] est_d [3];

  assign acc_v[0] = angle_acc_q;
  assign acc_v[1] = speed_acc_q;
  assign acc_v[2] = torque_acc_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x_d[i]   = acc_v[i][31] ? -acc_v[i] : acc_v[i];
      sum_d[i] = {1'b0, x_d[i]} + 33'(x_d[i] >> 15) + 33'd1;
      rem_d[i] = {1'b0, x_q[i]} + 33'(q0_q[i]) - 33'({q0_q[i], 15'b0});
      q_d[i]   = q0_q[i] + 17'(rem_d[i] >= SCALE);
      est_d[i] = neg_q[i] ? 16'(-q_d[i]) : q_d[i][15:0];
    end
  end

  // config and observer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_gain_q      <= '0;
      ki_gain_q      <= '0;
      kd_gain_base_q <= '0;
      kp_shift_q     <= '0;
      ki_shift_q     <= '0;
      kd_shift_q     <= '0;
      speed_mult_q   <= '0;
      speed_div_q    <= DIVISOR_W'(1);
      angle_acc_q    <= '0;
      speed_acc_q    <= '0;
      torque_acc_q   <= '0;
      angle_est_q    <= '0;
      speed_est_q    <= '0;
      torque_est_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_KP_GAIN:      kp_gain_q      <= $signed(cfg_data_i);
          CFG_KI_GAIN:      ki_gain_q      <= $signed(cfg_data_i);
          CFG_KD_GAIN_BASE: kd_gain_base_q <= $signed(cfg_data_i);
          CFG_KP_SHIFT:     kp_shift_q     <= cfg_data_i[4:0];
          CFG_KI_SHIFT:     ki_shift_q     <= cfg_data_i[4:0];
          CFG_KD_SHIFT:     kd_shift_q     <= cfg_data_i[4:0];
          CFG_SPEED_MULT:   speed_mult_q   <= cfg_data_i[DIVISOR_W-1:0];
          CFG_SPEED_DIV:    speed_div_q    <= cfg_data_i[DIVISOR_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.clr) begin
        angle_acc_q  <= (ha32 <<< 15) - ha32;
        speed_acc_q  <= (hs32 <<< 15) - hs32;
        torque_acc_q <= '0;
        angle_est_q  <= hall_angle_q;
        speed_est_q  <= hall_speed_q;
        torque_est_q <= '0;
      end
      if (cmd_i.upd1) begin
        angle_acc_q  <= na;
        torque_acc_q <= nt;
      end
      if (cmd_i.upd2) begin
        speed_acc_q <= ns;
      end
      if (cmd_i.est2) begin
        angle_est_q  <= $signed(est_d[0]);
        speed_est_q  <= $signed(est_d[1]);
        torque_est_q <= $signed(est_d[2]);
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      kind_q         <= kind_i;
      hall_angle_q   <= hall_angle_i;
      hall_speed_q   <= hall_speed_i;
      drive_torque_q <= drive_torque_i;
    end
    if (cmd_i.sine_idx) begin
      t_q       <= t_d;
      sin_neg_q <= idx[QW+1];
    end
    if (cmd_i.mul_op != MUL_NONE) begin
      prod_q <= prod_d;
    end
    case (cmd_i.wb_op)
      WB_T2:   t2_q     <= prod_hi;
      WB_P1:   p_q      <= SIN_C2 - prod_hi;
      WB_P2:   p_q      <= SIN_C1 - prod_hi;
      WB_P3:   p_q      <= SIN_C0 - prod_hi;
      WB_SIN:  e_q      <= e_d;
      WB_KD:   term_a_q <= $signed(prod_q[31:0]) >>> kd_shift_q;
      WB_KP:   term_s_q <= $signed(prod_q[31:0]) >>> kp_shift_q;
      WB_KI:   term_t_q <= $signed(prod_q[31:0]) >>> ki_shift_q;
      default: ;
    endcase
    if (cmd_i.gain) begin
      bg_q <= bg_d;
    end
    if (cmd_i.upd1) begin
      tmp_s_q <= tmp_s_d;
    end
    if (cmd_i.est1) begin
      for (int i = 0; i < 3; i++) begin
        x_q[i]   <= x_d[i];
        q0_q[i]  <= sum_d[i][31:15];
        neg_q[i] <= acc_v[i][31];
      end
    end
    if (cmd_i.out_load) begin
      out_angle_q  <= angle_est_q;
      out_speed_q  <= speed_est_q;
      out_torque_q <= torque_est_q;
    end
  end

  assign status_o.kind_clear = kind_q;
  assign status_o.div_done   = div_done;

  assign est_angle_o  = out_angle_q;
  assign est_speed_o  = out_speed_q;
  assign est_torque_o = out_torque_q;

endmodule

/* design/rato_ctrl.sv */
// Rotor angle tracking observer: controller state machine.
// Sequences the datapath and owns the input and result channel handshakes. Depends on rato_pkg.
`timescale 1ns / 1ps

module rato_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  rato_pkg::status_t status_i,
  output rato_pkg::cmd_t    cmd_o
);
  import rato_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DECODE, ST_CLEAR, ST_SIDX,
    ST_S1, ST_S2, ST_S3, ST_S4, ST_S5, ST_S6, ST_S7, ST_S8, ST_S9, ST_S10,
    ST_WDIV, ST_GAIN, ST_K1, ST_K2, ST_K3, ST_K4,
    ST_U1, ST_U2, ST_E1, ST_E2, ST_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o.load_in  = 1'b0;
    cmd_o.clr      = 1'b0;
    cmd_o.sine_idx = 1'b0;
    cmd_o.mul_op   = MUL_NONE;
    cmd_o.wb_op    = WB_NONE;
    cmd_o.gain     = 1'b0;
    cmd_o.upd1     = 1'b0;
    cmd_o.upd2     = 1'b0;
    cmd_o.est1     = 1'b0;
    cmd_o.est2     = 1'b0;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: state_d = status_i.kind_clear ? ST_CLEAR : ST_SIDX;
      ST_CLEAR: begin cmd_o.clr = 1'b1; state_d = ST_OUT; end
      ST_SIDX:  begin cmd_o.sine_idx = 1'b1; state_d = ST_S1; end
      ST_S1:    begin cmd_o.mul_op = MUL_TT; state_d = ST_S2; end
      ST_S2: begin
        cmd_o.wb_op  = WB_T2;
        cmd_o.mul_op = MUL_MAG;
        state_d      = ST_S3;
      end
      ST_S3: begin
        cmd_o.wb_op  = WB_MAG;
        cmd_o.mul_op = MUL_C3T2;
        state_d      = ST_S4;
      end
      ST_S4:  begin cmd_o.wb_op = WB_P1;   state_d = ST_S5;  end
      ST_S5:  begin cmd_o.mul_op = MUL_PT2; state_d = ST_S6; end
      ST_S6:  begin cmd_o.wb_op = WB_P2;   state_d = ST_S7;  end
      ST_S7:  begin cmd_o.mul_op = MUL_PT2; state_d = ST_S8; end
      ST_S8:  begin cmd_o.wb_op = WB_P3;   state_d = ST_S9;  end
      ST_S9:  begin cmd_o.mul_op = MUL_TP; state_d = ST_S10; end
      ST_S10: begin cmd_o.wb_op = WB_SIN;  state_d = ST_WDIV; end
      ST_WDIV: begin
        if (status_i.div_done) state_d = ST_GAIN;
      end
      ST_GAIN: begin cmd_o.gain = 1'b1; state_d = ST_K1; end
      ST_K1:   begin cmd_o.mul_op = MUL_BG; state_d = ST_K2; end
      ST_K2: begin
        cmd_o.wb_op  = WB_KD;
        cmd_o.mul_op = MUL_KP;
        state_d      = ST_K3;
      end
      ST_K3: begin
        cmd_o.wb_op  = WB_KP;
        cmd_o.mul_op = MUL_KI;
        state_d      = ST_K4;
      end
      ST_K4: begin cmd_o.wb_op = WB_KI; state_d = ST_U1; end
      ST_U1: begin cmd_o.upd1 = 1'b1;  state_d = ST_U2; end
      ST_U2: begin cmd_o.upd2 = 1'b1;  state_d = ST_E1; end
      ST_E1: begin cmd_o.est1 = 1'b1;  state_d = ST_E2; end
      ST_E2: begin cmd_o.est2 = 1'b1;  state_d = ST_OUT; end
      ST_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* design/rotor_angle_tracking_observer_top.sv */
// Rotor angle tracking observer, top level.
// Channel    Dir  Handshake     Payload
// in_i       in   valid/ready   kind, hall_angle, hall_speed, drive_torque
// out_o      out  valid/ready   est_angle, est_speed, est_torque
// cfg_i      in   valid/ready   index (4 b), data (16 b); ready always high
// A step item takes longer than a clear item to reach a valid result; the step
// time is set by the bit-serial divider of the gain boost.
// One item is in work at a time; the next is accepted while a result waits.
// A result that is not taken stalls only the final load of the next item.
// Reset is asynchronous, active low; no clearing pass. Depends on rato_pkg,
// rato_if, rato_ctrl, rato_dp.
`timescale 1ns / 1ps

module rotor_angle_tracking_observer_top #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rato_in_if.sink    in_i,
  rato_out_if.source out_o,
  rato_cfg_if.sink   cfg_i
);
  import rato_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_i.ready = 1'b1;

  rato_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rato_dp #(
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .kind_i         (in_i.kind),
    .hall_angle_i   (in_i.hall_angle),
    .hall_speed_i   (in_i.hall_speed),
    .drive_torque_i (in_i.drive_torque),
    .cfg_we_i       (cfg_i.valid & cfg_i.ready),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .est_angle_o    (out_o.est_angle),
    .est_speed_o    (out_o.est_speed),
    .est_torque_o   (out_o.est_torque)
  );

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("item accepted while another is in work");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_o.valid || out_o.ready))
    else $error("result register overwritten before it was taken");

  a_gain_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.gain |-> status.div_done)
    else $error("gain boost taken before the divider finished");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> cmd.load_in)
    else $error("accepted item not captured");

endmodule
